// ----- src/countdown_timer_mmss_controller_assert.svh -----
// assertion macros shared by the checker of the countdown timer
// depends on nothing; each macro expands to one labelled concurrent assertion
`ifndef COUNTDOWN_TIMER_MMSS_CONTROLLER_ASSERT_SVH
`define COUNTDOWN_TIMER_MMSS_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define CTM_ASSERT_IMPLY(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("countdown timer check failed");

// next-cycle implication, disabled while dis is high
`define CTM_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("countdown timer check failed");

`endif

// ----- src/ctm_pkg.sv -----
// shared types, codes and digit helpers of the countdown timer
// no dependencies
`default_nettype none

package ctm_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_SETSEC = 3'd1,
        MODE_SETMIN = 3'd2,
        MODE_RUN    = 3'd3,
        MODE_PAUSE  = 3'd4,
        MODE_ALARM  = 3'd5
    } t_mode;

    localparam logic [2:0] OP_DISPLAY = 3'd0;
    localparam logic [2:0] OP_SECOND  = 3'd1;
    localparam logic [2:0] OP_FAST    = 3'd2;
    localparam logic [2:0] OP_EDGE0   = 3'd3;
    localparam logic [2:0] OP_EDGE1   = 3'd4;

    localparam logic [2:0] CFG_PRESET_MIN = 3'd0;
    localparam logic [2:0] CFG_PRESET_SEC = 3'd1;
    localparam logic [2:0] CFG_BLINK      = 3'd2;
    localparam logic [2:0] CFG_DEBOUNCE   = 3'd3;
    localparam logic [2:0] CFG_BUZZER     = 3'd4;

    localparam logic [5:0]  PRESET_RESET   = 6'd59;
    localparam logic [9:0]  BLINK_RESET    = 10'd20;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd20;
    localparam logic [15:0] BUZZER_RESET   = 16'd500;
    localparam logic [5:0]  SEC_MAX        = 6'd59;
    localparam logic [6:0]  SEC_WRAP       = 7'd60;

    // decoded event of one item
    typedef struct packed {
        logic disp;
        logic sec;
        logic fast;
        logic edge0;
        logic edge1;
    } t_event;

    // tens digit of a 6-bit value (0..63)
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [6:0] tens10;
        logic [6:0] diff;
        tens10 = 7'(tens_of(v)) * 7'd10;
        diff   = {1'b0, v} - tens10;
        return diff[3:0];
    endfunction

    // seven-segment pattern, bit0 a .. bit6 g
    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h3F;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- src/ctm_debounce.sv -----
// one button debounce: pending flag and fast-tick counter
// depends on ctm_pkg
`default_nettype none

module ctm_debounce
    import ctm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire logic       i_fast,
    input  wire logic       i_edge,
    input  wire logic       i_level,
    input  wire logic [7:0] i_limit,
    output logic            o_hit
);

    logic       r_pend, n_pend;
    logic [7:0] r_count, n_count;
    logic [8:0] inc;

    always_comb begin
        n_pend  = r_pend;
        n_count = r_count;
        o_hit   = 1'b0;
        inc     = {1'b0, r_count} + 9'd1;
        if (i_edge) begin
            n_pend = 1'b1;
        end
        if (i_fast && r_pend) begin
            if (inc >= {1'b0, i_limit}) begin
                o_hit   = !i_level;
                n_pend  = 1'b0;
                n_count = 8'd0;
            end else begin
                n_count = inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_count <= 8'd0;
        end else if (i_adv) begin
            r_pend  <= n_pend;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- src/ctm_display.sv -----
// digit scan, blink phase and segment / enable latches
// depends on ctm_pkg
`default_nettype none

module ctm_display
    import ctm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire logic       i_disp,
    input  wire t_mode      i_mode,
    input  wire logic [5:0] i_min,
    input  wire logic [5:0] i_sec,
    input  wire logic [9:0] i_blink_ticks,
    output logic      [6:0] o_seg,
    output logic      [3:0] o_en
);

    logic [1:0]  r_scan, n_scan;
    logic        r_phase, n_phase;
    logic [9:0]  r_count, n_count;
    logic [6:0]  r_seg, n_seg;
    logic [3:0]  r_en, n_en;
    logic        show_min, show_sec, show;
    logic [5:0]  value;
    logic [3:0]  digit;
    logic [10:0] inc;

    always_comb begin
        show_min = !((i_mode == MODE_SETMIN) && !r_phase);
        show_sec = !((i_mode == MODE_SETSEC) && !r_phase);
        show     = r_scan[1] ? show_sec : show_min;
        value    = r_scan[1] ? i_sec : i_min;
        digit    = r_scan[0] ? units_of(value) : tens_of(value);
        inc      = {1'b0, r_count} + 11'd1;

        n_scan  = r_scan;
        n_phase = r_phase;
        n_count = r_count;
        n_seg   = r_seg;
        n_en    = r_en;
        if (i_disp) begin
            n_en = 4'd0;
            if (show) begin
                n_seg = seg_of(digit);
                n_en  = 4'd1 << r_scan;
            end
            n_scan = r_scan + 2'd1;
            if (inc >= {1'b0, i_blink_ticks}) begin
                n_phase = !r_phase;
                n_count = 10'd0;
            end else begin
                n_count = inc[9:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= 2'd0;
            r_phase <= 1'b0;
            r_count <= 10'd0;
            r_seg   <= 7'd0;
            r_en    <= 4'd0;
        end else if (i_adv) begin
            r_scan  <= n_scan;
            r_phase <= n_phase;
            r_count <= n_count;
            r_seg   <= n_seg;
            r_en    <= n_en;
        end
    end

    assign o_seg = r_seg;
    assign o_en  = r_en;

endmodule

`default_nettype wire

// ----- src/countdown_timer_mmss_controller.sv -----
// minutes:seconds countdown timer, top level
// depends on ctm_pkg, ctm_debounce and ctm_display
//
// usage
//   input channel : i_in_valid / o_in_stall carry one event item (i_op plus the two
//                   raw button levels); an item is taken when valid is high and
//                   stall is low
//   output channel: o_out_valid / i_out_stall carry one result item per event: the
//                   segment and digit-enable latches, buzzer, mode and time left
//   config port   : i_cfg_valid / o_cfg_ready with register index and data;
//                   always ready; the user must write only while no item is in
//                   flight, the block itself does not enforce it
//   path          : input register, then the state update forming the result
//   throughput    : one item per cycle when not stalled (single state update pass)
//   stall         : a stalled result holds all state; the input register keeps
//                   taking one item and then stalls the sender too
//   reset         : synchronous, active low; idle mode, 59:59 presets, all
//                   counters, latches and the pipeline valids cleared
`default_nettype none

module countdown_timer_mmss_controller
    import ctm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // event items
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic        i_button0_level,
    input  wire logic        i_button1_level,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [6:0]  o_segments,
    output logic      [3:0]  o_digit_enable,
    output logic             o_buzzer,
    output logic      [2:0]  o_mode,
    output logic      [5:0]  o_minutes_left,
    output logic      [5:0]  o_seconds_left,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // configuration registers
    logic [5:0]  r_preset_min, r_preset_sec;
    logic [9:0]  r_blink_ticks;
    logic [7:0]  r_debounce_ticks;
    logic [15:0] r_buzzer_half;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_op;
    logic        r_lvl0, r_lvl1;

    // output valid and timer state, which doubles as the result register
    logic        r_out_valid;
    t_mode       r_mode, n_mode;
    logic [5:0]  r_min, n_min, r_sec, n_sec;
    logic        r_buzz, n_buzz;
    logic [15:0] r_buzz_count, n_buzz_count;

    logic        adv;
    t_event      ev;
    logic        hit0, hit1;
    logic [16:0] buzz_inc;

    // result slot free or being emptied this cycle
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset_min     <= PRESET_RESET;
            r_preset_sec     <= PRESET_RESET;
            r_blink_ticks    <= BLINK_RESET;
            r_debounce_ticks <= DEBOUNCE_RESET;
            r_buzzer_half    <= BUZZER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRESET_MIN: r_preset_min     <= i_cfg_data[5:0];
                CFG_PRESET_SEC: r_preset_sec     <= i_cfg_data[5:0];
                CFG_BLINK:      r_blink_ticks    <= i_cfg_data[9:0];
                CFG_DEBOUNCE:   r_debounce_ticks <= i_cfg_data[7:0];
                CFG_BUZZER:     r_buzzer_half    <= i_cfg_data;
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // input register takes an item whenever it is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_in_valid || adv) begin
            r_op   <= i_op;
            r_lvl0 <= i_button0_level;
            r_lvl1 <= i_button1_level;
        end
    end

    // event decode, unknown codes give no event
    always_comb begin
        ev = '0;
        unique case (r_op)
            OP_DISPLAY: ev.disp  = 1'b1;
            OP_SECOND:  ev.sec   = 1'b1;
            OP_FAST:    ev.fast  = 1'b1;
            OP_EDGE0:   ev.edge0 = 1'b1;
            OP_EDGE1:   ev.edge1 = 1'b1;
            default: ;
        endcase
    end

    ctm_debounce u_deb0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_fast  (ev.fast),
        .i_edge  (ev.edge0),
        .i_level (r_lvl0),
        .i_limit (r_debounce_ticks),
        .o_hit   (hit0)
    );

    ctm_debounce u_deb1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_fast  (ev.fast),
        .i_edge  (ev.edge1),
        .i_level (r_lvl1),
        .i_limit (r_debounce_ticks),
        .o_hit   (hit1)
    );

    ctm_display u_disp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_disp        (ev.disp),
        .i_mode        (r_mode),
        .i_min         (r_min),
        .i_sec         (r_sec),
        .i_blink_ticks (r_blink_ticks),
        .o_seg         (o_segments),
        .o_en          (o_digit_enable)
    );

    // (v + 1) mod 60 for any 6-bit v
    function automatic logic [5:0] inc_wrap(input logic [5:0] v);
        logic [6:0] s;
        s = {1'b0, v} + 7'd1;
        if (s >= SEC_WRAP) s = s - SEC_WRAP;
        return s[5:0];
    endfunction

    // timer, buzzer and button actions; button 0 acts before button 1
    always_comb begin
        n_mode       = r_mode;
        n_min        = r_min;
        n_sec        = r_sec;
        n_buzz       = r_buzz;
        n_buzz_count = r_buzz_count;
        buzz_inc     = {1'b0, r_buzz_count} + 17'd1;

        if (ev.sec && (r_mode == MODE_RUN)) begin
            if (r_sec != 6'd0) begin
                n_sec = r_sec - 6'd1;
            end else if (r_min != 6'd0) begin
                n_min = r_min - 6'd1;
                n_sec = SEC_MAX;
            end else begin
                n_mode = MODE_ALARM;
            end
        end

        if (ev.fast) begin
            if (r_mode == MODE_ALARM) begin
                if (buzz_inc >= {1'b0, r_buzzer_half}) begin
                    n_buzz       = !r_buzz;
                    n_buzz_count = 16'd0;
                end else begin
                    n_buzz_count = buzz_inc[15:0];
                end
            end else begin
                n_buzz       = 1'b0;
                n_buzz_count = 16'd0;
            end
        end

        if (hit0) begin
            unique case (n_mode)
                MODE_IDLE:   n_mode = MODE_RUN;
                MODE_SETSEC: n_sec  = inc_wrap(n_sec);
                MODE_SETMIN: n_min  = inc_wrap(n_min);
                MODE_RUN:    n_mode = MODE_PAUSE;
                MODE_PAUSE:  n_mode = MODE_RUN;
                MODE_ALARM: begin
                    n_mode = MODE_IDLE;
                    n_min  = r_preset_min;
                    n_sec  = r_preset_sec;
                end
                default: ;
            endcase
        end

        if (hit1) begin
            unique case (n_mode)
                MODE_IDLE:   n_mode = MODE_SETSEC;
                MODE_SETSEC: n_mode = MODE_SETMIN;
                MODE_SETMIN: n_mode = MODE_IDLE;
                MODE_ALARM: begin
                    n_mode = MODE_IDLE;
                    n_min  = r_preset_min;
                    n_sec  = r_preset_sec;
                end
                default: ;  // running and paused ignore button 1
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_min        <= PRESET_RESET;
            r_sec        <= PRESET_RESET;
            r_buzz       <= 1'b0;
            r_buzz_count <= 16'd0;
        end else if (adv) begin
            r_mode       <= n_mode;
            r_min        <= n_min;
            r_sec        <= n_sec;
            r_buzz       <= n_buzz;
            r_buzz_count <= n_buzz_count;
        end
    end

    // result valid follows each state update until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_buzzer       = r_buzz;
    assign o_mode         = r_mode;
    assign o_minutes_left = r_min;
    assign o_seconds_left = r_sec;

endmodule

`default_nettype wire

// ----- src/ctm_checker.sv -----
// port-level checks of the countdown timer, bound to the top level
// depends on countdown_timer_mmss_controller_assert.svh
`default_nettype none
`include "countdown_timer_mmss_controller_assert.svh"

module ctm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [2:0]  i_op,
    input wire logic        i_button0_level,
    input wire logic        i_button1_level,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [6:0]  o_segments,
    input wire logic [3:0]  o_digit_enable,
    input wire logic        o_buzzer,
    input wire logic [2:0]  o_mode,
    input wire logic [5:0]  o_minutes_left,
    input wire logic [5:0]  o_seconds_left,
    input wire logic        i_cfg_valid,
    input wire logic        o_cfg_ready,
    input wire logic [2:0]  i_cfg_index,
    input wire logic [15:0] i_cfg_data
);

    logic [18:0] result;
    assign result = {o_segments, o_digit_enable, o_buzzer, o_mode, o_minutes_left[3:0]};

    // a stalled result keeps its display, seconds and minutes[3:0]
    `CTM_ASSERT_NEXT(a_result_held, i_clk, !i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(result) && $stable(o_seconds_left))

    // at most one digit lit while a result is valid
    `CTM_ASSERT_IMPLY(a_digit_onehot, i_clk, !i_rst_n, o_out_valid, $onehot0(o_digit_enable))

    // reset leaves no result pending and nothing stalled
    `CTM_ASSERT_NEXT(a_reset_clears, i_clk, 1'b0, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind countdown_timer_mmss_controller ctm_checker u_ctm_checker (.*);

`default_nettype wire
